// ===== hw/rtl/fqfs_pkg.sv =====
// Package for the fair queue flow scheduler: status codes, register
// indexes, field widths and the shared command, status and record types.
// No dependencies.
package fqfs_pkg;

  localparam int RATE_W   = 16;
  localparam int MSS_W    = 16;
  localparam int BYTES_W  = 34;
  localparam int FIN_W    = 48;
  localparam int LINK_W   = 14;
  localparam int MINF_W   = 7;
  localparam int HDR_W    = 8;
  localparam int CNT_W    = 7;
  localparam int RSV_W    = 17;
  localparam int STAT_W   = 3;
  localparam int SLOTO_W  = 6;
  localparam int CFG_A_W  = 2;
  localparam int CFG_D_W  = 14;
  // increment = seg * reserved * 2^NUM_SHIFT / (rate * link)
  localparam int NUM_SHIFT = 9;
  localparam int NUM_W    = MSS_W + RSV_W + NUM_SHIFT;
  localparam int DEN_W    = RATE_W + LINK_W;
  localparam int DCNT_W   = $clog2(NUM_W + 1);

  localparam logic [FIN_W-1:0] FIN_MAX = {FIN_W{1'b1}};

  localparam logic [LINK_W-1:0] LINK_RESET = LINK_W'(10240);
  localparam logic [MINF_W-1:0] MINF_RESET = MINF_W'(1);
  localparam logic [HDR_W-1:0]  HDR_RESET  = HDR_W'(36);

  localparam logic [CFG_A_W-1:0] CFG_LINK_RATE = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_MIN_FLOWS = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_HDR_OVH   = 2'd2;

  localparam logic [STAT_W-1:0] ST_ADMITTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STAT_W-1:0] ST_SENT      = 3'd3;
  localparam logic [STAT_W-1:0] ST_NO_FLOW   = 3'd4;

  localparam logic OP_ADMIT = 1'b0;
  localparam logic OP_SEND  = 1'b1;

  typedef struct packed {
    logic [RATE_W-1:0]  rate;
    logic [MSS_W-1:0]   seg_limit;
    logic [BYTES_W-1:0] total;
    logic [BYTES_W-1:0] sent;
    logic [FIN_W-1:0]   finish;
  } slot_rec_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [SLOTO_W-1:0] slot;
    logic [BYTES_W-1:0] byte_offset;
    logic [MSS_W-1:0]   seg_bytes;
    logic [FIN_W-1:0]   finish_time;
    logic               last_segment;
    logic               sending_on;
  } result_t;

  typedef struct packed {
    logic capture;
    logic admit;
    logic no_flow;
    logic scan_clr;
    logic cnt_inc;
    logic rd;
    logic rd_best;
    logic seg;
    logic mul;
    logic div_init;
    logic div_step;
    logic cand;
    logic upd;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic op_send;
    logic started;
    logic slot_busy;
    logic cnt_last;
    logic div_last;
    logic best_valid;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== hw/rtl/fqfs_ctrl.sv =====
// Controller of the fair queue flow scheduler: sequences admission,
// the per-slot candidate scan and the update of the served flow.
// Depends on fqfs_pkg.
module fqfs_ctrl import fqfs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  dp_stat_t st,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_ADMIT, S_NOFLOW, S_RD, S_SEG, S_MUL, S_DINIT, S_DIV,
    S_CAND, S_END, S_BRD, S_BSEG, S_BUPD, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          cmd.scan_clr = 1'b1;
          state_nxt = S_ADMIT;
        end
      end
      S_ADMIT: begin
        if (!st.op_send) begin
          cmd.admit = 1'b1;
          state_nxt = S_DONE;
        end else if (!st.started) begin
          state_nxt = S_NOFLOW;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_NOFLOW: begin
        cmd.no_flow = 1'b1;
        state_nxt = S_DONE;
      end
      S_RD: begin
        if (st.slot_busy) begin
          cmd.rd = 1'b1;
          state_nxt = S_SEG;
        end else if (st.cnt_last) begin
          state_nxt = S_END;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_SEG: begin
        cmd.seg = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) state_nxt = S_CAND;
      end
      S_CAND: begin
        cmd.cand = 1'b1;
        if (st.cnt_last) begin
          state_nxt = S_END;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_END: begin
        state_nxt = st.best_valid ? S_BRD : S_NOFLOW;
      end
      S_BRD: begin
        cmd.rd = 1'b1;
        cmd.rd_best = 1'b1;
        state_nxt = S_BSEG;
      end
      S_BSEG: begin
        cmd.seg = 1'b1;
        state_nxt = S_BUPD;
      end
      S_BUPD: begin
        cmd.upd = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/fqfs_dp.sv =====
// Datapath of the fair queue flow scheduler: configuration registers,
// slot table memory, serial divider, candidate compare and output register.
// Depends on fqfs_pkg.
module fqfs_dp import fqfs_pkg::*; #(
  parameter int MAX_FLOWS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [CFG_D_W-1:0] cfg_wdata,
  input  logic               in_op,
  input  logic [RATE_W-1:0]  in_rate,
  input  logic [MSS_W-1:0]   in_mss,
  input  logic [BYTES_W-1:0] in_bytes,
  input  logic               in_found,
  input  logic               out_tready,
  output logic               out_valid,
  output result_t            out_res,
  input  dp_cmd_t            cmd,
  output dp_stat_t           st
);

  localparam int SLOT_W = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_FLOWS - 1);

  logic [LINK_W-1:0] link_rate_r;
  logic [MINF_W-1:0] min_flows_r;
  logic [HDR_W-1:0]  hdr_ovh_r;

  logic               op_r;
  logic [RATE_W-1:0]  rate_r;
  logic [MSS_W-1:0]   mss_r;
  logic [BYTES_W-1:0] bytes_r;
  logic               found_r;

  logic [MAX_FLOWS-1:0] busy_r, busy_nxt;
  logic [FIN_W-1:0]     gfin_r;
  logic [CNT_W-1:0]     active_r, active_nxt;
  logic [RSV_W-1:0]     rsv_r, rsv_nxt;
  logic                 started_r, started_nxt;

  slot_rec_t slot_mem [MAX_FLOWS];
  slot_rec_t rd_q;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  slot_rec_t         wr_data;

  logic [SLOT_W-1:0]  cnt_r;
  logic [MSS_W-1:0]   seg_r;
  logic [NUM_W-1:0]   num_r;
  logic [DEN_W-1:0]   den_r;
  logic [DEN_W-1:0]   rem_r;
  logic [NUM_W-1:0]   quo_r;
  logic [DCNT_W-1:0]  dcnt_r;
  logic [SLOT_W-1:0]  best_idx_r;
  logic [FIN_W-1:0]   best_fin_r;
  logic               best_valid_r;

  result_t res_r, res_nxt;
  logic    out_valid_r;
  result_t out_r;

  // admission search
  logic              free_any;
  logic [SLOT_W-1:0] pick;
  logic              fits;
  logic [HDR_W-1:0]  unused_hdr;

  always_comb begin
    free_any = 1'b0;
    pick = '0;
    for (int i = MAX_FLOWS - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        free_any = 1'b1;
        pick = SLOT_W'(i);
      end
    end
  end

  assign fits = ({2'b00, rate_r} + {1'b0, rsv_r}) <= {4'b0000, link_rate_r};
  assign unused_hdr = '0;

  // segment size of the record just read
  logic [BYTES_W-1:0] left;
  logic [MSS_W-1:0]   seg_c;

  always_comb begin
    left = rd_q.total - rd_q.sent;
    if (rd_q.sent > rd_q.total) left = '0;
    seg_c = (left < {{(BYTES_W-MSS_W){1'b0}}, rd_q.seg_limit}) ? left[MSS_W-1:0]
                                                              : rd_q.seg_limit;
  end

  // divider step
  logic [DEN_W:0] rem_sh;
  logic [DEN_W:0] rem_diff;
  assign rem_sh   = {rem_r, quo_r[NUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, den_r};

  // candidate finish time
  logic [FIN_W:0]   cand_sum;
  logic [FIN_W-1:0] cand;
  logic [NUM_W-1:0] qsum;
  assign qsum = quo_r;
  assign cand_sum = {1'b0, rd_q.finish} + {{(FIN_W+1-NUM_W){1'b0}}, qsum};
  always_comb begin
    if (den_r == '0)           cand = FIN_MAX;
    else if (cand_sum[FIN_W])  cand = FIN_MAX;
    else                       cand = cand_sum[FIN_W-1:0];
  end

  // served flow update
  logic [BYTES_W-1:0] new_sent;
  logic               freed;
  assign new_sent = rd_q.sent + {{(BYTES_W-MSS_W){1'b0}}, seg_r};
  assign freed = new_sent >= rd_q.total;

  logic [MSS_W-1:0] seg_lim_c;
  assign seg_lim_c = (mss_r > {unused_hdr, hdr_ovh_r}) ? (mss_r - {unused_hdr, hdr_ovh_r})
                                                        : '0;

  always_comb begin
    busy_nxt = busy_r;
    active_nxt = active_r;
    rsv_nxt = rsv_r;
    started_nxt = started_r;
    res_nxt = res_r;
    wr_en = 1'b0;
    wr_addr = pick;
    wr_data = rd_q;
    if (cmd.admit) begin
      res_nxt = '0;
      if (!(free_any && fits)) begin
        res_nxt.status = ST_FULL;
      end else if (!found_r) begin
        res_nxt.status = ST_NOT_FOUND;
      end else begin
        busy_nxt[pick] = 1'b1;
        active_nxt = active_r + CNT_W'(1);
        rsv_nxt = rsv_r + {1'b0, rate_r};
        wr_en = 1'b1;
        wr_data.rate = rate_r;
        wr_data.seg_limit = seg_lim_c;
        wr_data.total = bytes_r;
        wr_data.sent = '0;
        wr_data.finish = gfin_r;
        res_nxt.status = ST_ADMITTED;
        res_nxt.slot = SLOTO_W'(pick);
      end
      if (free_any && fits && !found_r) begin
        started_nxt = started_r;
      end else if (active_nxt >= min_flows_r || rsv_nxt >= {3'b000, link_rate_r}) begin
        started_nxt = 1'b1;
      end
      res_nxt.sending_on = started_nxt;
    end else if (cmd.no_flow) begin
      res_nxt = '0;
      res_nxt.status = ST_NO_FLOW;
      res_nxt.sending_on = started_r;
    end else if (cmd.upd) begin
      wr_en = 1'b1;
      wr_addr = best_idx_r;
      wr_data.sent = new_sent;
      wr_data.finish = best_fin_r;
      res_nxt.status = ST_SENT;
      res_nxt.slot = SLOTO_W'(best_idx_r);
      res_nxt.byte_offset = rd_q.sent;
      res_nxt.seg_bytes = seg_r;
      res_nxt.finish_time = best_fin_r;
      res_nxt.last_segment = freed;
      if (freed) begin
        busy_nxt[best_idx_r] = 1'b0;
        rsv_nxt = rsv_r - {1'b0, rd_q.rate};
        active_nxt = active_r - CNT_W'(1);
        if (active_nxt == '0) started_nxt = 1'b0;
      end
      res_nxt.sending_on = started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) slot_mem[wr_addr] <= wr_data;
    if (cmd.rd) rd_q <= slot_mem[cmd.rd_best ? best_idx_r : cnt_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_rate_r <= LINK_RESET;
      min_flows_r <= MINF_RESET;
      hdr_ovh_r <= HDR_RESET;
      busy_r <= '0;
      gfin_r <= '0;
      active_r <= '0;
      rsv_r <= '0;
      started_r <= 1'b0;
      best_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_LINK_RATE: link_rate_r <= cfg_wdata[LINK_W-1:0];
          CFG_MIN_FLOWS: min_flows_r <= cfg_wdata[MINF_W-1:0];
          CFG_HDR_OVH:   hdr_ovh_r <= cfg_wdata[HDR_W-1:0];
          default: ;
        endcase
      end
      busy_r <= busy_nxt;
      active_r <= active_nxt;
      rsv_r <= rsv_nxt;
      started_r <= started_nxt;
      if (cmd.upd) gfin_r <= best_fin_r;
      if (cmd.scan_clr) begin
        best_valid_r <= 1'b0;
      end else if (cmd.cand && (!best_valid_r || cand < best_fin_r)) begin
        best_valid_r <= 1'b1;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (cmd.capture) begin
      op_r <= in_op;
      rate_r <= in_rate;
      mss_r <= in_mss;
      bytes_r <= in_bytes;
      found_r <= in_found;
    end
    if (cmd.scan_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + SLOT_W'(1);
    end
    if (cmd.seg) seg_r <= seg_c;
    if (cmd.mul) begin
      num_r <= NUM_W'({seg_r, NUM_SHIFT'(0)} * {{(NUM_W-RSV_W){1'b0}}, rsv_r});
      den_r <= rd_q.rate * {{(DEN_W-LINK_W){1'b0}}, link_rate_r};
    end
    if (cmd.div_init) begin
      rem_r <= '0;
      quo_r <= num_r;
      dcnt_r <= DCNT_W'(NUM_W);
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r - DCNT_W'(1);
      if (!rem_diff[DEN_W]) begin
        rem_r <= rem_diff[DEN_W-1:0];
        quo_r <= {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[DEN_W-1:0];
        quo_r <= {quo_r[NUM_W-2:0], 1'b0};
      end
    end
    if (cmd.cand && (!best_valid_r || cand < best_fin_r)) begin
      best_idx_r <= cnt_r;
      best_fin_r <= cand;
    end
    if (cmd.load_out) out_r <= res_r;
  end

  assign st.op_send    = (op_r == OP_SEND);
  assign st.started    = started_r;
  assign st.slot_busy  = busy_r[cnt_r];
  assign st.cnt_last   = (cnt_r == LAST_SLOT);
  assign st.div_last   = (dcnt_r == DCNT_W'(1));
  assign st.best_valid = best_valid_r;
  assign st.out_free   = !out_valid_r || out_tready;

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

// ===== hw/rtl/fair_queue_flow_scheduler_top.sv =====
// Top level of the fair queue flow scheduler: port packing, controller
// and datapath. Depends on fqfs_pkg, fqfs_ctrl and fqfs_dp.
//
// channel  direction  payload
// in_      slave      tuser: operation; tdata: request fields
// out_     master     tdata: result fields; tlast: last_segment
// cfg_     write      index 0 link_rate, 1 min_flows, 2 header_overhead
//
// Admit answers, and no_flow answers before start, skip the slot scan.
// A send scans every slot and runs the bit-serial 42-step divider once per
// busy slot to form its candidate finish time; a send that finds no
// flow after the scan answers no_flow.
// Reset clears control state at once; the slot table needs no clearing pass.
// One request is in flight at a time; a result waiting on out_tready does
// not block acceptance of the next request.
module fair_queue_flow_scheduler_top import fqfs_pkg::*; #(
  parameter int MAX_FLOWS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CFG_A_W-1:0]  cfg_addr,
  input  logic [CFG_D_W-1:0]  cfg_wdata,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic                in_tuser,   // operation
  // flow_rate[15:0], max_seg[31:16], image_bytes[65:32], image_found[66]
  input  logic [71:0]         in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic                out_tlast,  // last_segment
  // status[2:0], slot[8:3], byte_offset[42:9], seg_bytes[58:43],
  // finish_time[106:59], sending_on[107]
  output logic [111:0]        out_tdata
);

  dp_cmd_t  cmd;
  dp_stat_t st;
  result_t  res;

  fqfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  fqfs_dp #(.MAX_FLOWS(MAX_FLOWS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_op      (in_tuser),
    .in_rate    (in_tdata[15:0]),
    .in_mss     (in_tdata[31:16]),
    .in_bytes   (in_tdata[65:32]),
    .in_found   (in_tdata[66]),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_res    (res),
    .cmd        (cmd),
    .st         (st)
  );

  assign out_tlast = res.last_segment;
  assign out_tdata = {4'b0000, res.sending_on, res.finish_time, res.seg_bytes,
                      res.byte_offset, res.slot, res.status};

endmodule

// ===== hw/rtl/fqfs_checker.sv =====
// Port checker for the fair queue flow scheduler and its bind to the top.
// Depends on fqfs_pkg and fair_queue_flow_scheduler_top.
module fqfs_checker import fqfs_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic         out_tlast,
  input logic [111:0] out_tdata
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_last_sent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[2:0] == ST_SENT)
    else $error("last segment on a non-send answer");

  a_one_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while one is in flight");

endmodule

bind fair_queue_flow_scheduler_top fqfs_checker u_fqfs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tlast  (out_tlast),
  .out_tdata  (out_tdata)
);

// ===== tb/sv/fqfs_scoreboard.sv =====
`timescale 1ns / 1ps
// Result checker for the fair queue flow scheduler: watches the config, request
// and result channels, predicts each result and compares it field by field.
// Depends on fqfs_pkg.
module fqfs_scoreboard import fqfs_pkg::*; #(
  parameter int MAX_FLOWS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [CFG_D_W-1:0] cfg_wdata,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic               in_tuser,
  input  logic [71:0]        in_tdata,
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic               out_tlast,
  input  logic [111:0]       out_tdata,
  output int                 mismatches,
  output int                 pending
);

  localparam logic [63:0] BYTES_MASK = 64'h3_FFFF_FFFF;

  logic [LINK_W-1:0]  link_rate;
  logic [MINF_W-1:0]  min_flows;
  logic [HDR_W-1:0]   hdr_ovh;

  logic               busy   [MAX_FLOWS];
  logic [RATE_W-1:0]  rate_of[MAX_FLOWS];
  logic [MSS_W-1:0]   limit  [MAX_FLOWS];
  logic [BYTES_W-1:0] total  [MAX_FLOWS];
  logic [BYTES_W-1:0] sent   [MAX_FLOWS];
  logic [FIN_W-1:0]   fin    [MAX_FLOWS];
  logic [FIN_W-1:0]   global_fin;
  logic [CNT_W-1:0]   active;
  logic [RSV_W-1:0]   reserved;
  logic               started;

  result_t expected_q[$];

  function automatic logic [63:0] seg_size(int i);
    logic [63:0] left;
    left = ({30'b0, total[i]} - {30'b0, sent[i]}) & BYTES_MASK;
    if (sent[i] > total[i]) left = 0;
    return (left < {48'b0, limit[i]}) ? left : {48'b0, limit[i]};
  endfunction

  function automatic logic [63:0] next_finish(int i);
    logic [63:0] den;
    logic [63:0] inc;
    logic [63:0] sum;
    den = {48'b0, rate_of[i]} * {50'b0, link_rate};
    if (den == 0) return {16'b0, FIN_MAX};
    inc = (seg_size(i) * {47'b0, reserved} * 64'd512) / den;
    sum = {16'b0, fin[i]} + inc;
    return (sum > {16'b0, FIN_MAX}) ? {16'b0, FIN_MAX} : sum;
  endfunction

  function automatic void update_started();
    if (!started && (active >= min_flows || reserved >= {3'b0, link_rate})) started = 1'b1;
  endfunction

  function automatic result_t schedule(logic op, logic [RATE_W-1:0] rate,
                                       logic [MSS_W-1:0] mss, logic [BYTES_W-1:0] bytes,
                                       logic found);
    result_t     r;
    int          pick;
    logic [63:0] c;
    logic [63:0] best_fin;
    logic [63:0] seg;
    r = '0;
    pick = -1;
    best_fin = 0;
    if (op == OP_ADMIT) begin
      if ({48'b0, rate} + {47'b0, reserved} <= {50'b0, link_rate}) begin
        for (int i = 0; i < MAX_FLOWS; i++)
          if (!busy[i] && pick < 0) pick = i;
      end
      if (pick < 0) begin
        r.status = ST_FULL;
      end else if (!found) begin
        r.status = ST_NOT_FOUND;
        r.sending_on = started;
        return r;
      end else begin
        busy[pick]    = 1'b1;
        rate_of[pick] = rate;
        limit[pick]   = (mss > {8'b0, hdr_ovh}) ? mss - {8'b0, hdr_ovh} : '0;
        total[pick]   = bytes;
        sent[pick]    = '0;
        fin[pick]     = global_fin;
        active        = active + 1'b1;
        reserved      = reserved + {1'b0, rate};
        r.status      = ST_ADMITTED;
        r.slot        = SLOTO_W'(pick);
      end
      update_started();
      r.sending_on = started;
      return r;
    end
    if (started) begin
      for (int i = 0; i < MAX_FLOWS; i++) begin
        if (busy[i]) begin
          c = next_finish(i);
          if (pick < 0 || c < best_fin) begin
            pick = i;
            best_fin = c;
          end
        end
      end
    end
    if (pick < 0) begin
      r.status = ST_NO_FLOW;
      r.sending_on = started;
      return r;
    end
    seg           = seg_size(pick);
    global_fin    = best_fin[FIN_W-1:0];
    fin[pick]     = best_fin[FIN_W-1:0];
    r.status      = ST_SENT;
    r.slot        = SLOTO_W'(pick);
    r.byte_offset = sent[pick];
    r.seg_bytes   = seg[MSS_W-1:0];
    r.finish_time = best_fin[FIN_W-1:0];
    sent[pick]    = sent[pick] + seg[BYTES_W-1:0];
    if (sent[pick] >= total[pick]) begin
      busy[pick] = 1'b0;
      reserved   = reserved - {1'b0, rate_of[pick]};
      active     = active - 1'b1;
      if (active == 0) started = 1'b0;
      r.last_segment = 1'b1;
    end
    r.sending_on = started;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      link_rate  = LINK_RESET;
      min_flows  = MINF_RESET;
      hdr_ovh    = HDR_RESET;
      for (int i = 0; i < MAX_FLOWS; i++) busy[i] = 1'b0;
      global_fin = '0;
      active     = '0;
      reserved   = '0;
      started    = 1'b0;
      expected_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_LINK_RATE: link_rate = cfg_wdata[LINK_W-1:0];
          CFG_MIN_FLOWS: min_flows = cfg_wdata[MINF_W-1:0];
          CFG_HDR_OVH:   hdr_ovh   = cfg_wdata[HDR_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.status       = out_tdata[2:0];
        got.slot         = out_tdata[8:3];
        got.byte_offset  = out_tdata[42:9];
        got.seg_bytes    = out_tdata[58:43];
        got.finish_time  = out_tdata[106:59];
        got.sending_on   = out_tdata[107];
        got.last_segment = out_tlast;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = expected_q.pop_front();
          if (got.status != want.status || got.slot != want.slot ||
              got.byte_offset != want.byte_offset || got.seg_bytes != want.seg_bytes ||
              got.finish_time != want.finish_time ||
              got.last_segment != want.last_segment || got.sending_on != want.sending_on) begin
            mismatches++;
            if (mismatches <= 10) $display("result mismatch: expected %p actual %p", want, got);
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_q.push_back(schedule(in_tuser, in_tdata[15:0], in_tdata[31:16],
                                      in_tdata[65:32], in_tdata[66]));
    end
    pending = expected_q.size();
  end

endmodule

// ===== tb/sv/tb_fair_queue_flow_scheduler_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the fair queue flow scheduler: clock, reset, request and
// config stimulus, result back-pressure and verdict. Depends on fqfs_pkg,
// fqfs_scoreboard and fair_queue_flow_scheduler_top.
module tb_fair_queue_flow_scheduler_top;
  import fqfs_pkg::*;

  localparam int STALL_LIMIT = 10000;
  localparam int HOLD_CYCLES = 3000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CFG_A_W-1:0] cfg_addr = '0;
  logic [CFG_D_W-1:0] cfg_wdata = '0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic               in_tuser = 1'b0;
  logic [71:0]        in_tdata = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic               out_tlast;
  logic [111:0]       out_tdata;
  int                 mismatches;
  int                 pending;
  int                 idle_cycles = 0;
  logic               hold_req = 1'b0;
  int                 link_now = 10240;
  int                 hdr_now = 36;

  always #2 clk = ~clk;

  fair_queue_flow_scheduler_top dut (.*);

  fqfs_scoreboard chk (.*);

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic request(logic op, logic [15:0] rate, logic [15:0] mss,
                         logic [33:0] bytes, logic found);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid = 1'b0;
      repeat (g) @(negedge clk);
    end
    in_tuser  = op;
    in_tdata  = {5'b0, found, bytes, mss, rate};
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_A_W-1:0] addr, int value);
    cfg_we    = 1'b1;
    cfg_addr  = addr;
    cfg_wdata = CFG_D_W'(value);
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic random_phase(int count);
    logic [15:0] rate;
    logic [15:0] mss;
    logic [33:0] bytes;
    logic        found;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 55) begin
        request(OP_SEND, 16'($urandom), 16'($urandom), 34'($urandom), 1'($urandom));
      end else begin
        found = ($urandom_range(0, 9) != 0);
        rate  = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                            : 16'($urandom_range(1, link_now / 4));
        mss   = 16'(hdr_now + 1 + $urandom_range(0, 3000));
        bytes = 34'($urandom_range(0, 4 * (mss - hdr_now)));
        if ($urandom_range(0, 19) == 0) begin
          mss = 16'($urandom);
          bytes = '0;
        end
        if (!found && $urandom_range(0, 1)) bytes = {2'($urandom), 32'($urandom)};
        request(OP_ADMIT, rate, mss, bytes, found);
      end
      if (n == 300) hold_req = 1'b1;
    end
    drain();
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_tready = (gap_len() == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (6) @(negedge clk);
    request(OP_SEND, '0, '0, '0, 1'b0);
    request(OP_ADMIT, 16'hFFFF, 16'd1500, 34'd1000, 1'b1);
    request(OP_ADMIT, 16'd100, 16'd0, 34'd0, 1'b1);
    request(OP_ADMIT, 16'd0, 16'hFFFF, 34'd100, 1'b1);
    request(OP_ADMIT, 16'd5000, 16'd1500, 34'd3000, 1'b0);
    request(OP_ADMIT, 16'd5000, 16'd1500, 34'd3000, 1'b1);
    request(OP_ADMIT, 16'd5140, 16'hFFFF, 34'd65535, 1'b1);
    request(OP_ADMIT, 16'd1, 16'd100, 34'd10, 1'b1);
    repeat (8) request(OP_SEND, '0, '0, '0, 1'b0);
    request(OP_ADMIT, 16'd1, 16'hFFFF, 34'h3_FFFF_FFFF, 1'b0);
    drain();
    random_phase(700);
    cfg_write(CFG_LINK_RATE, 1024);
    cfg_write(CFG_MIN_FLOWS, 64);
    cfg_write(CFG_HDR_OVH, 0);
    link_now = 1024;
    hdr_now = 0;
    random_phase(150);
    cfg_write(CFG_LINK_RATE, 10240);
    cfg_write(CFG_MIN_FLOWS, 3);
    cfg_write(CFG_HDR_OVH, 255);
    link_now = 10240;
    hdr_now = 255;
    random_phase(450);
    cfg_write(CFG_LINK_RATE, 5000);
    cfg_write(CFG_MIN_FLOWS, 8);
    cfg_write(CFG_HDR_OVH, 100);
    cfg_write(2'd3, 16383);
    link_now = 5000;
    hdr_now = 100;
    random_phase(500);
    request(OP_ADMIT, 16'd1, 16'd10, 34'd50, 1'b1);
    repeat (6) request(OP_SEND, '0, '0, '0, 1'b0);
    drain();
    repeat (500) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/fqfs_pkg.sv
hw/rtl/fqfs_ctrl.sv
hw/rtl/fqfs_dp.sv
hw/rtl/fair_queue_flow_scheduler_top.sv
hw/rtl/fqfs_checker.sv
tb/sv/fqfs_scoreboard.sv
tb/sv/tb_fair_queue_flow_scheduler_top.sv
